@@ hw/rtl/ptft_pkg.sv @@
// ----------------------------------------------------------------------------
// ptft_pkg
// Shared types, codes and helpers of the packet trace flow table.
// ----------------------------------------------------------------------------
`default_nettype none

package ptft_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_LOOK,
    ST_MATCH,
    ST_UPD
  } state_t;

  localparam logic       CMD_RECORD = 1'b0;
  localparam logic       CMD_ROTATE = 1'b1;

  localparam logic [1:0] STAT_NEW     = 2'd0;
  localparam logic [1:0] STAT_UPDATED = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_ROTATED = 2'd3;

  localparam logic [31:0] HASH_MULT   = 32'd59;
  localparam logic [7:0]  LOOP_RESET  = 8'd3;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic [15:0] ident;
  } key_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/packet_trace_flow_table.sv @@
// ----------------------------------------------------------------------------
// packet_trace_flow_table
// Two-generation hashed trace table: key match, entry create, hop tracking.
// ----------------------------------------------------------------------------
// A record beat keeps busy high through row reduce, row read of both
// generations, entry read and write back; when ROWS is not a power of two
// the row reduce is a row remainder in the steps reciprocal multiply,
// multiply back and subtract, final compare and subtract. The result is on
// the outputs for one cycle, marked by out_valid, in the cycle in which busy
// falls; the receiver cannot stall, so there is no backpressure. A rotate
// beat clears the new newer generation's valid rows one row a cycle, result
// as busy falls. After reset the block sweeps 2**(ROW_W+1) valid rows with
// busy high before it takes a start. cfg_we may be written at any time the
// block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_trace_flow_table import ptft_pkg::*; #(
  parameter int ROWS      = 1024,
  parameter int COLUMNS   = 8,
  parameter int HOP_SLOTS = 5
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_command,
  input  wire logic [31:0] in_src_addr,
  input  wire logic [31:0] in_dst_addr,
  input  wire logic [7:0]  in_proto,
  input  wire logic [15:0] in_ident,
  input  wire logic [7:0]  in_switch_tag,
  input  wire logic [9:0]  in_time_low,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic             out_generation,
  output logic [9:0]       out_row_index,
  output logic [2:0]       out_column_index,
  output logic             out_loop_flag,
  output logic             out_drop_flag,
  output logic [2:0]       out_hops_used,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_data
);

  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RA_W  = ROW_W + 1;
  localparam int EA_W  = RA_W + COL_W;
  localparam bit ROWS_POW2 = ((ROWS & (ROWS - 1)) == 0);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
  // floor(2**32 / ROWS); only used when ROWS is not a power of two
  localparam logic [31:0] RECIP  = 32'((64'd1 << 32) / 64'(ROWS));
  localparam logic [31:0] ROWS32 = 32'(ROWS);
  localparam logic [16:0] ROWS17 = 17'(ROWS);

  typedef struct packed {
    logic [7:0]                  first_sw;
    logic [7:0]                  first_cnt;
    logic                        loop;
    logic                        drop;
    logic [9:0]                  start_t;
    logic [HOP_SLOTS-1:0][7:0]   hsw;
    logic [HOP_SLOTS-1:0][7:0]   hcnt;
    logic [HOP_SLOTS-1:0][9:0]   hshift;
  } entry_t;

  // memories
  key_t   [COLUMNS-1:0] key_mem   [2**RA_W];
  logic   [COLUMNS-1:0] valid_mem [2**RA_W];
  entry_t               ent_mem   [2**EA_W];

  state_t state_r, state_nxt;

  logic             newer_r;
  logic [7:0]       thr_r;
  key_t             key_r;
  logic [7:0]       sw_r;
  logic [9:0]       tlow_r;
  logic [31:0]      hash_r;
  logic [31:0]      quot_r;
  logic [16:0]      fold_r;
  logic [4:0]       mod_cnt_r;
  logic [ROW_W-1:0] row_r;
  logic             gen_r, hit_r, full_r;
  logic [COL_W-1:0] col_r;
  logic [COLUMNS-1:0] vnew_r;
  logic [EA_W-1:0]  ent_addr_r;
  logic [ROW_W:0]   clr_r;
  logic             clr_all_r;

  key_t [COLUMNS-1:0] key_old_q, key_new_q;
  logic [COLUMNS-1:0] v_old_q, v_new_q;
  entry_t             ent_q;

  // control decodes
  logic accept, mod_done, clr_last;
  logic [63:0] recip_prod;
  logic [31:0] quot_back, fold;

  assign accept = start && (state_r == ST_IDLE);
  // quotient estimate is exact or one low, so the remainder is below 2*ROWS
  assign recip_prod = {32'd0, hash_r} * {32'd0, RECIP};
  assign quot_back  = quot_r * ROWS32;
  assign fold       = hash_r - quot_back;
  assign mod_done = ROWS_POW2 || (mod_cnt_r == 5'd2);
  assign clr_last = clr_all_r ? (&clr_r) : (clr_r[ROW_W-1:0] == ROW_LAST);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (start) state_nxt = (in_command == CMD_ROTATE) ? ST_CLEAR : ST_MOD;
      end
      ST_MOD:   if (mod_done) state_nxt = ST_LOOK;
      ST_LOOK:  state_nxt = ST_MATCH;
      ST_MATCH: state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // lookup: match both generations, pick column
  logic [COLUMNS-1:0] m_old, m_new;
  logic [COL_W-1:0]   c_old, c_new, c_free;
  logic               hit_old, hit_new, has_free;
  logic               sel_gen;
  logic [COL_W-1:0]   sel_col;

  always_comb begin
    c_old  = '0;
    c_new  = '0;
    c_free = '0;
    for (int c = 0; c < COLUMNS; c++) begin
      m_old[c] = v_old_q[c] && (key_old_q[c] == key_r);
      m_new[c] = v_new_q[c] && (key_new_q[c] == key_r);
    end
    for (int c = COLUMNS - 1; c >= 0; c--) begin
      if (m_old[c])    c_old  = COL_W'(c);
      if (m_new[c])    c_new  = COL_W'(c);
      if (!v_new_q[c]) c_free = COL_W'(c);
    end
    hit_old  = |m_old;
    hit_new  = |m_new;
    has_free = ~&v_new_q;
    sel_gen  = !hit_old;
    sel_col  = hit_old ? c_old : (hit_new ? c_new : c_free);
  end

  // entry update
  entry_t     e_upd;
  logic [4:0] used;
  logic       found, placed;

  always_comb begin
    e_upd  = ent_q;
    found  = 1'b0;
    placed = 1'b0;
    used   = '0;
    if (hit_r) begin
      if (e_upd.first_sw == sw_r) begin
        e_upd.first_cnt = sat_inc(ent_q.first_cnt);
        if (e_upd.first_cnt >= thr_r) e_upd.loop = 1'b1;
      end
      for (int h = 0; h < HOP_SLOTS; h++) begin
        if (!found && (ent_q.hcnt[h] != 8'd0) && (ent_q.hsw[h] == sw_r)) begin
          found         = 1'b1;
          e_upd.hcnt[h] = sat_inc(ent_q.hcnt[h]);
          if (e_upd.hcnt[h] >= thr_r) e_upd.loop = 1'b1;
        end
      end
      if (!found) begin
        for (int h = 0; h < HOP_SLOTS; h++) begin
          if (!placed && (ent_q.hcnt[h] == 8'd0)) begin
            placed          = 1'b1;
            e_upd.hsw[h]    = sw_r;
            e_upd.hcnt[h]   = 8'd1;
            e_upd.hshift[h] = tlow_r - ent_q.start_t;
          end
        end
        if (!placed) e_upd.drop = 1'b1;
      end
    end else begin
      e_upd.first_sw  = sw_r;
      e_upd.first_cnt = 8'd1;
      e_upd.loop      = 1'b0;
      e_upd.drop      = 1'b1;
      e_upd.start_t   = tlow_r;
      e_upd.hcnt      = '0;
    end
    for (int h = 0; h < HOP_SLOTS; h++) begin
      used = used + {4'd0, (e_upd.hcnt[h] != 8'd0)};
    end
  end

  // memory port controls
  logic             vwr_en;
  logic [RA_W-1:0]  vwr_addr;
  logic [COLUMNS-1:0] vwr_data;
  logic             rd_row_en, rd_ent_en, ent_wr_en, key_wr_en;
  logic [EA_W-1:0]  ent_rd_addr;

  always_comb begin
    busy      = (state_r != ST_IDLE);
    rd_row_en = (state_r == ST_LOOK);
    rd_ent_en = (state_r == ST_MATCH);
    ent_wr_en = (state_r == ST_UPD) && !full_r;
    key_wr_en = ent_wr_en && !hit_r;
    vwr_en    = (state_r == ST_CLEAR) || key_wr_en;
    vwr_addr  = {newer_r, row_r};
    vwr_data  = vnew_r | (COLUMNS'(1) << col_r);
    if (state_r == ST_CLEAR) begin
      vwr_addr = clr_all_r ? clr_r : {newer_r, clr_r[ROW_W-1:0]};
      vwr_data = '0;
    end
    ent_rd_addr = {(sel_gen ? newer_r : ~newer_r), row_r, sel_col};
  end

  always_ff @(posedge clk) begin
    if (rd_row_en) begin
      key_old_q <= key_mem[{~newer_r, row_r}];
      key_new_q <= key_mem[{newer_r, row_r}];
      v_old_q   <= valid_mem[{~newer_r, row_r}];
      v_new_q   <= valid_mem[{newer_r, row_r}];
    end
    if (vwr_en) valid_mem[vwr_addr] <= vwr_data;
    if (key_wr_en) key_mem[{newer_r, row_r}][col_r] <= key_r;
  end

  always_ff @(posedge clk) begin
    if (rd_ent_en) ent_q <= ent_mem[ent_rd_addr];
    if (ent_wr_en) ent_mem[ent_addr_r] <= e_upd;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      newer_r   <= 1'b0;
      thr_r     <= LOOP_RESET;
      clr_r     <= '0;
      clr_all_r <= 1'b1;
      mod_cnt_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= (state_r == ST_UPD) ||
                   ((state_r == ST_CLEAR) && clr_last && !clr_all_r);
      if (cfg_we) thr_r <= cfg_data;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (accept) begin
        mod_cnt_r <= '0;
        if (in_command == CMD_ROTATE) begin
          newer_r   <= ~newer_r;
          clr_r     <= '0;
          clr_all_r <= 1'b0;
        end
      end
      if (state_r == ST_MOD) mod_cnt_r <= mod_cnt_r + 5'd1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r  <= '{src: in_src_addr, dst: in_dst_addr, proto: in_proto, ident: in_ident};
      sw_r   <= in_switch_tag;
      tlow_r <= in_time_low;
      hash_r <= (in_src_addr * HASH_MULT) ^ in_dst_addr ^ {24'd0, in_proto}
                ^ {16'd0, in_ident};
    end
    if (state_r == ST_MOD) begin
      if (ROWS_POW2) begin
        row_r <= (ROWS == 1) ? '0 : hash_r[ROW_W-1:0];
      end else begin
        if (mod_cnt_r == 5'd0) quot_r <= recip_prod[63:32];
        if (mod_cnt_r == 5'd1) fold_r <= fold[16:0];
        if (mod_cnt_r == 5'd2) begin
          row_r <= (fold_r >= ROWS17) ? ROW_W'(fold_r - ROWS17) : ROW_W'(fold_r);
        end
      end
    end
    if (state_r == ST_MATCH) begin
      gen_r      <= sel_gen;
      col_r      <= sel_col;
      hit_r      <= hit_old || hit_new;
      full_r     <= !(hit_old || hit_new) && !has_free;
      vnew_r     <= v_new_q;
      ent_addr_r <= ent_rd_addr;
    end
    if (state_r == ST_UPD) begin
      out_row_index <= 10'(32'(row_r));
      if (full_r) begin
        out_status       <= STAT_FULL;
        out_generation   <= 1'b1;
        out_column_index <= '0;
        out_loop_flag    <= 1'b0;
        out_drop_flag    <= 1'b0;
        out_hops_used    <= '0;
      end else begin
        out_status       <= hit_r ? STAT_UPDATED : STAT_NEW;
        out_generation   <= gen_r;
        out_column_index <= 3'(32'(col_r));
        out_loop_flag    <= e_upd.loop;
        out_drop_flag    <= e_upd.drop;
        out_hops_used    <= used[2:0];
      end
    end else if (state_r == ST_CLEAR) begin
      out_status       <= STAT_ROTATED;
      out_generation   <= 1'b0;
      out_row_index    <= '0;
      out_column_index <= '0;
      out_loop_flag    <= 1'b0;
      out_drop_flag    <= 1'b0;
      out_hops_used    <= '0;
    end
  end

endmodule

`default_nettype wire
